### src/hsvrgb_pkg.sv
// Package for the HSV to RGB converter.
// Fixed-point formats, hue sector constants and the sector type.
// No dependencies.
package hsvrgb_pkg;

  localparam int FRAC_BITS = 12;
  localparam int CH_W      = 13;
  localparam int HUE_W     = 15;
  localparam int REM_W     = 12;
  localparam int PROD_W    = 24;
  localparam int SCALE_W   = 2 * CH_W;

  localparam logic [CH_W-1:0] ONE = CH_W'(1 << FRAC_BITS);

  localparam logic [HUE_W-1:0] HUE_SECTOR = HUE_W'(3840);
  localparam logic [HUE_W-1:0] HUE_FULL   = HUE_W'(23040);

  // divide by 3840 = (x >> 8) / 15; the /15 by reciprocal, exact below 2^16
  localparam int DIV_SHIFT  = 8;
  localparam int QUO_W      = PROD_W - DIV_SHIFT;
  localparam int RECIP_W    = 2 * QUO_W;
  localparam int RECIP_SH   = 19;
  localparam logic [QUO_W-1:0] RECIP_15 = QUO_W'(34953);

  typedef enum logic [2:0] {
    SECT_RED_YEL,
    SECT_YEL_GRN,
    SECT_GRN_CYN,
    SECT_CYN_BLU,
    SECT_BLU_MAG,
    SECT_MAG_RED
  } sector_t;

endpackage

### src/hsv_to_rgb_converter.sv
// HSV to RGB converter, five-stage pipeline.
// Depends on hsvrgb_pkg.
//
// Usage:
//   Input channel: in_valid / in_stall with hue (1/64 degree, 15 bits),
//   saturation and brightness (Q12, 4096 = 1.0, larger values clamp to 1.0).
//   Output channel: out_valid / out_stall with red, green, blue (Q12).
//   An item moves on each rising edge where valid is high and stall is low.
//   Hue of 23040 (360 degrees) or more is taken as zero.
//
// With no stalls the pipeline takes one item every cycle; the stages are
// clamp and sector split, the s*f and p products, the reciprocal divide by
// 3840, the q and t products, and the channel select.
//
// Each stage holds its own valid bit and advances when it is empty or the
// next stage advances, so bubbles collapse and in_stall only rises when all
// stages are full and out_stall is high. A stall neither drops nor repeats
// an item. Reset empties the pipeline; payload registers are not reset.
module hsv_to_rgb_converter
  import hsvrgb_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [HUE_W-1:0] hue,
  input  logic [CH_W-1:0]  saturation,
  input  logic [CH_W-1:0]  brightness,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [CH_W-1:0]  red,
  output logic [CH_W-1:0]  green,
  output logic [CH_W-1:0]  blue
);

  logic en1, en2, en3, en4, en5;
  logic valid1, valid2, valid3, valid4;

  // stage 1: clamp, sector and remainder
  logic [HUE_W-1:0] hh, base;
  logic [CH_W-1:0]  s_c, v_c;
  sector_t          sect_c;
  logic [REM_W-1:0] rem_c;

  logic [CH_W-1:0]  s1, v1;
  logic [REM_W-1:0] rem1;
  sector_t          sect1;

  // stage 2: products
  logic [PROD_W-1:0]  pf2, pc2;
  logic [SCALE_W-1:0] pp2;
  logic [CH_W-1:0]    v2;
  sector_t            sect2;

  // stage 3: sf, sf', p
  logic [RECIP_W-1:0] qf_c, qc_c;
  logic [CH_W-1:0]    sf3, sfc3, p3, v3;
  sector_t            sect3;

  // stage 4: q and t products
  logic [SCALE_W-1:0] qp4, tp4;
  logic [CH_W-1:0]    p4, v4;
  sector_t            sect4;

  logic [CH_W-1:0] q_c, t_c;

  assign en5 = !out_valid || !out_stall;
  assign en4 = !valid4 || en5;
  assign en3 = !valid3 || en4;
  assign en2 = !valid2 || en3;
  assign en1 = !valid1 || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1    <= 1'b0;
      valid2    <= 1'b0;
      valid3    <= 1'b0;
      valid4    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) valid1 <= in_valid;
      if (en2) valid2 <= valid1;
      if (en3) valid3 <= valid2;
      if (en4) valid4 <= valid3;
      if (en5) out_valid <= valid4;
    end
  end

  always_comb begin
    hh  = (hue >= HUE_FULL) ? '0 : hue;
    s_c = (saturation > ONE) ? ONE : saturation;
    v_c = (brightness > ONE) ? ONE : brightness;
    if (hh >= HUE_W'(5 * HUE_SECTOR)) begin
      sect_c = SECT_MAG_RED;
      base   = HUE_W'(5 * HUE_SECTOR);
    end else if (hh >= HUE_W'(4 * HUE_SECTOR)) begin
      sect_c = SECT_BLU_MAG;
      base   = HUE_W'(4 * HUE_SECTOR);
    end else if (hh >= HUE_W'(3 * HUE_SECTOR)) begin
      sect_c = SECT_CYN_BLU;
      base   = HUE_W'(3 * HUE_SECTOR);
    end else if (hh >= HUE_W'(2 * HUE_SECTOR)) begin
      sect_c = SECT_GRN_CYN;
      base   = HUE_W'(2 * HUE_SECTOR);
    end else if (hh >= HUE_SECTOR) begin
      sect_c = SECT_YEL_GRN;
      base   = HUE_SECTOR;
    end else begin
      sect_c = SECT_RED_YEL;
      base   = '0;
    end
    rem_c = REM_W'(hh - base);
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1    <= s_c;
      v1    <= v_c;
      rem1  <= rem_c;
      sect1 <= sect_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      pf2   <= PROD_W'(s1) * PROD_W'(rem1);
      pc2   <= PROD_W'(s1) * (PROD_W'(HUE_SECTOR) - PROD_W'(rem1));
      pp2   <= SCALE_W'(v1) * SCALE_W'(ONE - s1);
      v2    <= v1;
      sect2 <= sect1;
    end
  end

  assign qf_c = RECIP_W'(pf2[PROD_W-1:DIV_SHIFT]) * RECIP_W'(RECIP_15);
  assign qc_c = RECIP_W'(pc2[PROD_W-1:DIV_SHIFT]) * RECIP_W'(RECIP_15);

  always_ff @(posedge clk) begin
    if (en3) begin
      sf3   <= qf_c[RECIP_SH +: CH_W];
      sfc3  <= qc_c[RECIP_SH +: CH_W];
      p3    <= pp2[FRAC_BITS +: CH_W];
      v3    <= v2;
      sect3 <= sect2;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      qp4   <= SCALE_W'(v3) * SCALE_W'(ONE - sf3);
      tp4   <= SCALE_W'(v3) * SCALE_W'(ONE - sfc3);
      p4    <= p3;
      v4    <= v3;
      sect4 <= sect3;
    end
  end

  assign q_c = qp4[FRAC_BITS +: CH_W];
  assign t_c = tp4[FRAC_BITS +: CH_W];

  always_ff @(posedge clk) begin
    if (en5) begin
      case (sect4)
        SECT_RED_YEL: begin red <= v4;  green <= t_c; blue <= p4;  end
        SECT_YEL_GRN: begin red <= q_c; green <= v4;  blue <= p4;  end
        SECT_GRN_CYN: begin red <= p4;  green <= v4;  blue <= t_c; end
        SECT_CYN_BLU: begin red <= p4;  green <= q_c; blue <= v4;  end
        SECT_BLU_MAG: begin red <= t_c; green <= p4;  blue <= v4;  end
        default:      begin red <= v4;  green <= p4;  blue <= q_c; end
      endcase
    end
  end

endmodule

### src/hsvrgb_checker.sv
// Port-level checks for hsv_to_rgb_converter, bound to the top level.
// Depends on hsvrgb_pkg.
module hsvrgb_checker
  import hsvrgb_pkg::*;
(
  input logic            clk,
  input logic            rst,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input logic [CH_W-1:0] red,
  input logic [CH_W-1:0] green,
  input logic [CH_W-1:0] blue
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid after reset");

  a_flow_through: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input stalled while output flows");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> red <= ONE && green <= ONE && blue <= ONE)
    else $error("channel above full scale");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(red) && $stable(green) && $stable(blue))
    else $error("stalled item changed");

endmodule

bind hsv_to_rgb_converter hsvrgb_checker u_hsvrgb_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .red(red), .green(green), .blue(blue)
);
